>>> design/dtm_pkg.sv
// Types and constants shared by the differential thrust mixer.
package dtm_pkg;

	localparam int unsigned LIM_W   = 15;
	localparam int unsigned TOUT_W  = 16;
	localparam int unsigned CMD_W   = 16;
	localparam int unsigned TIME_W  = 32;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DAT_W = 16;

	localparam logic [LIM_W-1:0]  DRIVE_LIM_RST = 15'd10000;
	localparam logic [LIM_W-1:0]  STEER_LIM_RST = 15'd5000;
	localparam logic [TOUT_W-1:0] TIMEOUT_RST   = 16'd1000;

	typedef enum logic [1:0] {
		KIND_THRUST = 2'd0,
		KIND_RUDDER = 2'd1,
		KIND_TICK   = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		STATUS_WAITING = 2'd0,
		STATUS_STALE   = 2'd1,
		STATUS_ACTIVE  = 2'd2
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DRIVE_LIM = 2'd0,
		REG_STEER_LIM = 2'd1,
		REG_TIMEOUT   = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [1:0]               kind;
		logic signed [CMD_W-1:0]  value;
		logic [TIME_W-1:0]        time_ms;
	} in_beat_t;

	typedef struct packed {
		logic signed [CMD_W-1:0]  left_drive;
		logic signed [CMD_W-1:0]  right_drive;
		logic [1:0]               status;
	} out_beat_t;

endpackage

>>> design/dtm_mix.sv
// Clamp and mix thrust and rudder into left and right drive commands.
module dtm_mix (
	input  logic signed [dtm_pkg::CMD_W-1:0] thrust_cmd,
	input  logic signed [dtm_pkg::CMD_W-1:0] rudder_cmd,
	input  logic [dtm_pkg::LIM_W-1:0]        drive_lim,
	input  logic [dtm_pkg::LIM_W-1:0]        steer_lim,
	output logic signed [dtm_pkg::CMD_W-1:0] left_drive,
	output logic signed [dtm_pkg::CMD_W-1:0] right_drive
);

	localparam int unsigned W = 20;

	function automatic logic signed [W-1:0] clamp_sym(
		input logic signed [W-1:0] x,
		input logic signed [W-1:0] lim
	);
		logic signed [W-1:0] res;
		res = x;
		if (x > lim) begin
			res = lim;
		end else if (x < -lim) begin
			res = -lim;
		end
		return res;
	endfunction

	logic signed [W-1:0] lim, rlim, t, r, l0, r0, l1, r1;

	always_comb begin
		lim  = signed'({{(W-dtm_pkg::LIM_W){1'b0}}, drive_lim});
		rlim = signed'({{(W-dtm_pkg::LIM_W){1'b0}}, steer_lim});
		t  = clamp_sym({{(W-dtm_pkg::CMD_W){thrust_cmd[dtm_pkg::CMD_W-1]}}, thrust_cmd}, lim);
		r  = clamp_sym({{(W-dtm_pkg::CMD_W){rudder_cmd[dtm_pkg::CMD_W-1]}}, rudder_cmd}, rlim);
		l0 = t + r;
		r0 = t - r;
		r1 = r0;
		if (l0 > lim) begin
			r1 = r0 - (l0 - lim);
		end else if (l0 < -lim) begin
			r1 = r0 - (l0 + lim);
		end
		l1 = l0;
		if (r1 > lim) begin
			l1 = l0 - (r1 - lim);
		end else if (r1 < -lim) begin
			l1 = l0 - (r1 + lim);
		end
	end

	logic signed [W-1:0] l_clamped, r_clamped;
	assign l_clamped   = clamp_sym(l1, lim);
	assign r_clamped   = clamp_sym(r1, lim);
	assign left_drive  = l_clamped[dtm_pkg::CMD_W-1:0];
	assign right_drive = r_clamped[dtm_pkg::CMD_W-1:0];

endmodule

>>> design/differential_thrust_mixer_top.sv
// Top level of the differential thrust mixer: command store, freshness check, result register.
//
//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+-------------------------------
//  in       | in  | in_valid/in_stall  | in_data  (kind, value, time_ms)
//  out      | out | out_valid/out_stall| out_data (left, right, status)
//  cfg      | in  | cfg_valid/cfg_ready| cfg_index, cfg_data
//
//  One beat per cycle while no stalled result holds the input register; a tick's result
//  passes through the input register, then the result register. Updates give no result.
//  Reset clears the seen flags, commands and stamps and loads the default limits.
//  A stalled result holds the result register and, through it, the input register.
module differential_thrust_mixer_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  dtm_pkg::in_beat_t                    in_data,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output dtm_pkg::out_beat_t                   out_data,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [dtm_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [dtm_pkg::CFG_DAT_W-1:0]        cfg_data
);

	logic [dtm_pkg::LIM_W-1:0]  drive_lim_q, steer_lim_q;
	logic [dtm_pkg::TOUT_W-1:0] timeout_q;

	logic signed [dtm_pkg::CMD_W-1:0] thrust_cmd_q, rudder_cmd_q;
	logic [dtm_pkg::TIME_W-1:0]       thrust_stamp_q, rudder_stamp_q;
	logic                             thrust_seen_q, rudder_seen_q;

	logic              valid_s1;
	dtm_pkg::in_beat_t data_s1;
	logic              out_valid_q;
	dtm_pkg::out_beat_t out_data_q;

	logic advance;
	assign advance   = !out_valid_q || !out_stall;
	assign in_stall  = valid_s1 && !advance;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drive_lim_q <= dtm_pkg::DRIVE_LIM_RST;
			steer_lim_q <= dtm_pkg::STEER_LIM_RST;
			timeout_q   <= dtm_pkg::TIMEOUT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				dtm_pkg::REG_DRIVE_LIM: drive_lim_q <= cfg_data[dtm_pkg::LIM_W-1:0];
				dtm_pkg::REG_STEER_LIM: steer_lim_q <= cfg_data[dtm_pkg::LIM_W-1:0];
				dtm_pkg::REG_TIMEOUT:   timeout_q   <= cfg_data[dtm_pkg::TOUT_W-1:0];
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			data_s1 <= in_data;
		end
	end

	// command store
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thrust_cmd_q   <= '0;
			rudder_cmd_q   <= '0;
			thrust_stamp_q <= '0;
			rudder_stamp_q <= '0;
			thrust_seen_q  <= 1'b0;
			rudder_seen_q  <= 1'b0;
		end else if (valid_s1 && advance) begin
			case (data_s1.kind)
				dtm_pkg::KIND_THRUST: begin
					thrust_cmd_q   <= data_s1.value;
					thrust_stamp_q <= data_s1.time_ms;
					thrust_seen_q  <= 1'b1;
				end
				dtm_pkg::KIND_RUDDER: begin
					rudder_cmd_q   <= data_s1.value;
					rudder_stamp_q <= data_s1.time_ms;
					rudder_seen_q  <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	logic [dtm_pkg::TIME_W-1:0] thrust_age, rudder_age;
	logic both_seen, fresh;
	logic signed [dtm_pkg::CMD_W-1:0] mix_left, mix_right;
	dtm_pkg::out_beat_t result;

	assign thrust_age = data_s1.time_ms - thrust_stamp_q;
	assign rudder_age = data_s1.time_ms - rudder_stamp_q;
	assign both_seen  = thrust_seen_q && rudder_seen_q;
	assign fresh = (thrust_age <= {{(dtm_pkg::TIME_W-dtm_pkg::TOUT_W){1'b0}}, timeout_q})
		&& (rudder_age <= {{(dtm_pkg::TIME_W-dtm_pkg::TOUT_W){1'b0}}, timeout_q});

	dtm_mix u_mix (
		.thrust_cmd  (thrust_cmd_q),
		.rudder_cmd  (rudder_cmd_q),
		.drive_lim   (drive_lim_q),
		.steer_lim   (steer_lim_q),
		.left_drive  (mix_left),
		.right_drive (mix_right)
	);

	always_comb begin
		result.left_drive  = '0;
		result.right_drive = '0;
		result.status      = dtm_pkg::STATUS_WAITING;
		if (both_seen && fresh) begin
			result.left_drive  = mix_left;
			result.right_drive = mix_right;
			result.status      = dtm_pkg::STATUS_ACTIVE;
		end else if (both_seen) begin
			result.status = dtm_pkg::STATUS_STALE;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1 && (data_s1.kind == dtm_pkg::KIND_TICK);
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1 && (data_s1.kind == dtm_pkg::KIND_TICK)) begin
			out_data_q <= result;
		end
	end

endmodule
